/* rtl/core/iale_pkg.sv */
// Shared types and codes for the indexed array list engine.
// No dependencies; imported by iale_cell and the top level.
package iale_pkg;

    // command codes
    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_APPEND   = 3'd1;
    localparam logic [2:0] MODE_REMOVE   = 3'd2;
    localparam logic [2:0] MODE_POP      = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;
    localparam logic [2:0] MODE_OVERWR   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int MODE_BITS   = 3;
    localparam int INDEX_BITS  = 7;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    // per-cycle action broadcast to every cell
    typedef struct packed {
        logic shift_up;    // cells above pos take left neighbor, pos takes value
        logic shift_down;  // cells at and above pos take right neighbor
        logic load;        // cell at pos takes value
    } t_cell_op;

endpackage

/* rtl/core/indexed_array_list_engine_top.sv */
// Indexed array list engine: ordered list of signed words in a row of cells.
// Depends on iale_pkg and iale_cell.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------
//  command | i_in_valid  | o_in_stall  | i_mode, i_index, i_value
//  result  | o_out_valid | i_out_stall | o_word, o_status, o_count
//
// One command per cycle while o_in_stall is low: every cell shifts in the same
// cycle as the command, and the read word ripples through the cell chain into
// the result register, so a result shows in the cycle after its request.
// Reset (i_rst_n low, synchronous) empties the list and drops the result.
// While the result register holds an untaken result and i_out_stall is
// high, o_in_stall is high and no new request is taken.
module indexed_array_list_engine_top #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [iale_pkg::MODE_BITS-1:0]      i_mode,
    input  logic [iale_pkg::INDEX_BITS-1:0]     i_index,
    input  logic signed [iale_pkg::VALUE_BITS-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [iale_pkg::VALUE_BITS-1:0] o_word,
    output logic [iale_pkg::STATUS_BITS-1:0]    o_status,
    output logic [iale_pkg::COUNT_BITS-1:0]     o_count
);
    import iale_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);              // count width
    localparam int LW = (CW > INDEX_BITS) ? CW : INDEX_BITS; // compare width
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    // handshake
    logic accept;
    logic r_out_valid;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // list length
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [LW-1:0] cnt_l;
    logic [LW-1:0] idx_l;

    assign cnt_l = LW'(r_count);
    assign idx_l = LW'(i_index);

    // value narrowed or sign-extended to the stored word width
    logic [WORD_BITS-1:0] store_val;
    generate
        if (WORD_BITS <= VALUE_BITS) begin : g_val_trunc
            assign store_val = i_value[WORD_BITS-1:0];
        end else begin : g_val_ext
            assign store_val = {{(WORD_BITS-VALUE_BITS){i_value[VALUE_BITS-1]}}, i_value};
        end
    endgenerate

    // command decode: cell action, positions, status
    t_cell_op      cell_op;
    logic [LW-1:0] op_pos;
    logic [LW-1:0] rd_pos;
    logic          rd_en;
    logic [1:0]    status;

    always_comb begin
        cell_op = '0;
        op_pos  = idx_l;
        rd_pos  = idx_l;
        rd_en   = 1'b0;
        status  = ST_OK;
        n_count = r_count;
        unique case (i_mode)
            MODE_INSERT: begin
                if (idx_l > cnt_l) begin
                    status = ST_RANGE;
                end else if (cnt_l >= CAP_L) begin
                    status = ST_FULL;
                end else begin
                    cell_op.shift_up = 1'b1;
                    n_count          = r_count + 1'b1;
                end
            end
            MODE_APPEND: begin
                // append is an insert at the current end
                op_pos = cnt_l;
                if (cnt_l >= CAP_L) begin
                    status = ST_FULL;
                end else begin
                    cell_op.shift_up = 1'b1;
                    n_count          = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (idx_l >= cnt_l) begin
                    status = ST_RANGE;
                end else begin
                    cell_op.shift_down = 1'b1;
                    rd_en              = 1'b1;
                    n_count            = r_count - 1'b1;
                end
            end
            MODE_POP: begin
                rd_pos = cnt_l - 1'b1;
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_READ: begin
                if (idx_l >= cnt_l) status = ST_RANGE;
                else                rd_en  = 1'b1;
            end
            MODE_OVERWR: begin
                if (idx_l >= cnt_l) begin
                    status = ST_RANGE;
                end else begin
                    cell_op.load = 1'b1;
                    rd_en        = 1'b1;
                end
            end
            default: begin
                // unused codes: no operation, status ok
            end
        endcase
        if (!accept) cell_op = '0;
    end

    // row of cells; chain[k] is the read chain entering cell k
    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] chain     [CAPACITY+1];

    assign chain[0] = '0;

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;
            if (k == 0) begin : g_first
                assign left_w = cell_word[k];
            end else begin : g_mid_l
                assign left_w = cell_word[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign right_w = cell_word[k];
            end else begin : g_mid_r
                assign right_w = cell_word[k+1];
            end
            iale_cell #(
                .K  (k),
                .WB (WORD_BITS),
                .LW (LW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_op       (cell_op),
                .i_pos      (op_pos),
                .i_rpos     (rd_pos),
                .i_value    (store_val),
                .i_left     (left_w),
                .i_right    (right_w),
                .i_rd_chain (chain[k]),
                .o_word     (cell_word[k]),
                .o_rd_chain (chain[k+1])
            );
        end
    endgenerate

    // read word sign-extended or cut to the port width
    logic [VALUE_BITS-1:0] rd_word;
    generate
        if (WORD_BITS >= VALUE_BITS) begin : g_rd_trunc
            assign rd_word = chain[CAPACITY][VALUE_BITS-1:0];
        end else begin : g_rd_ext
            assign rd_word = {{(VALUE_BITS-WORD_BITS){chain[CAPACITY][WORD_BITS-1]}},
                              chain[CAPACITY]};
        end
    endgenerate

    // result register
    logic [VALUE_BITS-1:0] r_word;
    logic [1:0]            r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= rd_en ? rd_word : '0;
            r_status <= status;
        end
    end

    // count register only moves with a request, so it matches the shown result
    assign o_word   = r_word;
    assign o_status = r_status;
    assign o_count  = COUNT_BITS'(r_count);

endmodule

/* rtl/core/iale_cell.sv */
// One list slot: holds a word, shifts with its neighbors, joins the read chain.
// Depends on iale_pkg (t_cell_op).
module iale_cell #(
    parameter int K  = 0,
    parameter int WB = 32,
    parameter int LW = 7
) (
    input  logic               i_clk,
    input  iale_pkg::t_cell_op i_op,
    input  logic [LW-1:0]      i_pos,
    input  logic [LW-1:0]      i_rpos,
    input  logic [WB-1:0]      i_value,
    input  logic [WB-1:0]      i_left,
    input  logic [WB-1:0]      i_right,
    input  logic [WB-1:0]      i_rd_chain,
    output logic [WB-1:0]      o_word,
    output logic [WB-1:0]      o_rd_chain
);
    import iale_pkg::*;

    localparam logic [LW-1:0] MY_POS = LW'(K);

    logic [WB-1:0] r_word;
    logic [WB-1:0] n_word;
    logic          at_pos;
    logic          above_pos;

    assign at_pos    = (i_pos == MY_POS);
    assign above_pos = (MY_POS > i_pos);

    always_comb begin
        n_word = r_word;
        if (i_op.shift_up) begin
            if (above_pos)   n_word = i_left;
            else if (at_pos) n_word = i_value;
        end else if (i_op.shift_down) begin
            if (above_pos || at_pos) n_word = i_right;
        end else if (i_op.load) begin
            if (at_pos) n_word = i_value;
        end
    end

    // storage is undefined until written: no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_rd_chain = i_rd_chain | (r_word & {WB{i_rpos == MY_POS}});

endmodule
